>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker modules of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: label");

// Concurrent assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed: label");

`endif

>>> design/jecs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jecs_pkg
// Types, constants and the byte-wise CRC-32 fold shared by the JSON escape
// CRC-32 stream block.
// ---------------------------------------------------------------------------
package jecs_pkg;

   // Reflected IEEE 802.3 polynomial and the all-ones seed / final mask.
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   // Characters used by the JSON string escapes.
   localparam logic [7:0] CHR_QUOTE     = 8'h22;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHR_BS        = 8'h08;
   localparam logic [7:0] CHR_FF        = 8'h0C;
   localparam logic [7:0] CHR_LF        = 8'h0A;
   localparam logic [7:0] CHR_CR        = 8'h0D;
   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_NUL       = 8'h00;
   localparam logic [7:0] CHR_LOW_B     = 8'h62;
   localparam logic [7:0] CHR_LOW_F     = 8'h66;
   localparam logic [7:0] CHR_LOW_N     = 8'h6E;
   localparam logic [7:0] CHR_LOW_R     = 8'h72;
   localparam logic [7:0] CHR_LOW_T     = 8'h74;
   localparam logic [7:0] CHR_LOW_U     = 8'h75;
   localparam logic [7:0] CHR_ZERO      = 8'h30;

   // One input item as held in the input register.
   typedef struct packed {
      logic       restart;
      logic       escape_mode;
      logic [7:0] data_byte;
   } jecs_item_type;

   // Folds one byte into a reflected CRC, one bit per step.
   function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc_in,
                                                 input logic [7:0]  data);
      logic [31:0] crc;
      crc = crc_in ^ {24'h000000, data};
      for (int k = 0; k < 8; k++) begin
         crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'h0000_0000);
      end
      return crc;
   endfunction

endpackage

>>> design/jecs_crc_update.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jecs_crc_update
// Expands one byte as a JSON string character when asked and folds the
// resulting one, two or six bytes into the running CRC in a single pass.
// ---------------------------------------------------------------------------
module jecs_crc_update
   import jecs_pkg::*;
(
   input  logic [31:0]   crc_cur,
   input  jecs_item_type item,
   output logic [31:0]   crc_next
);

   logic [7:0]  tag;
   logic        has_tag;
   logic        is_nul;
   logic [31:0] crc_base;
   logic [7:0]  first_byte;
   logic [7:0]  second_byte;
   logic [31:0] fold_1;
   logic [31:0] fold_2;
   logic [31:0] fold_3;
   logic [31:0] fold_4;
   logic [31:0] fold_5;
   logic [31:0] fold_6;

   // Escape decoder: the character that follows the backslash.
   always_comb begin
      has_tag = 1'b1;
      unique case (item.data_byte)
         CHR_QUOTE:     tag = CHR_QUOTE;
         CHR_BACKSLASH: tag = CHR_BACKSLASH;
         CHR_BS:        tag = CHR_LOW_B;
         CHR_FF:        tag = CHR_LOW_F;
         CHR_LF:        tag = CHR_LOW_N;
         CHR_CR:        tag = CHR_LOW_R;
         CHR_TAB:       tag = CHR_LOW_T;
         default: begin
            tag     = CHR_NUL;
            has_tag = 1'b0;
         end
      endcase
   end

   assign is_nul = (item.data_byte == CHR_NUL);

   // A restart seeds the CRC before the first byte of this item.
   assign crc_base = item.restart ? CRC_ONES : crc_cur;

   // Byte sequence: backslash leads every escape; a zero byte becomes \u0000.
   assign first_byte  = (item.escape_mode && (has_tag || is_nul)) ? CHR_BACKSLASH
                                                                  : item.data_byte;
   assign second_byte = is_nul ? CHR_LOW_U : tag;

   // Fold chain over the longest expansion.
   assign fold_1 = crc_fold_byte(crc_base, first_byte);
   assign fold_2 = crc_fold_byte(fold_1, second_byte);
   assign fold_3 = crc_fold_byte(fold_2, CHR_ZERO);
   assign fold_4 = crc_fold_byte(fold_3, CHR_ZERO);
   assign fold_5 = crc_fold_byte(fold_4, CHR_ZERO);
   assign fold_6 = crc_fold_byte(fold_5, CHR_ZERO);

   // Pick the tap that matches the length of the expansion.
   always_comb begin
      if (!item.escape_mode) begin
         crc_next = fold_1;
      end else if (has_tag) begin
         crc_next = fold_2;
      end else if (is_nul) begin
         crc_next = fold_6;
      end else begin
         crc_next = fold_1;
      end
   end

endmodule

>>> design/json_escape_crc32_stream.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// json_escape_crc32_stream
// Running reflected CRC-32 over a byte stream, with optional JSON string
// escaping of each byte; every transaction returns the checksum so far.
// ---------------------------------------------------------------------------
//
//   channel   direction  tdata                 tuser
//   req_      in         [7:0] data_byte       [0] escape_mode, [1] restart
//   rsp_      out        [31:0] checksum       -
//
// One transaction per cycle is sustained while the output is not stalled; a
// result is offered once its request has passed the input register and the
// result register. The CRC update of up to six expanded bytes sits
// between the input register and the result register, and the CRC register
// closes the loop in the same cycle.
// Reset (synchronous) empties both stages and seeds the CRC with all ones.
// A stalled output holds its result while the input stage still takes one
// more transaction.
// ---------------------------------------------------------------------------
module json_escape_crc32_stream
   import jecs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [0] escape_mode, [1] restart
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] checksum
);

   logic          in_valid_ff;
   logic          in_valid_in;
   jecs_item_type in_item_ff;
   logic [31:0]   crc_ff;
   logic [31:0]   crc_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic [31:0]   out_sum_ff;
   logic          advance;
   logic          req_take;
   logic [31:0]   crc_update;

   // The result stage moves whenever it is empty or being drained.
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // Escape expansion and CRC fold for the item in the input register.
   jecs_crc_update u_crc_update (
      .crc_cur  (crc_ff),
      .item     (in_item_ff),
      .crc_next (crc_update)
   );

   // Next-state logic for the valid flags and the CRC register.
   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      crc_in       = crc_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
         if (in_valid_ff) begin
            crc_in = crc_update;
         end
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         crc_ff       <= CRC_ONES;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         crc_ff       <= crc_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= '{restart:     req_tuser[1],
                         escape_mode: req_tuser[0],
                         data_byte:   req_tdata};
      end
      if (advance && in_valid_ff) begin
         out_sum_ff <= crc_update ^ CRC_ONES;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sum_ff;

endmodule

>>> design/jecs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jecs_checker
// Port-level checks for the JSON escape CRC-32 stream block, bound to the
// top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jecs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // No result is pending right after reset.
   `ASSERT_CLK_ALWAYS(a_idle_after_reset, clock, reset |=> !rsp_tvalid)

   // An empty result stage never blocks the request side.
   `ASSERT_CLK(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready)

   // A stalled result stays offered.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // A stalled result keeps its checksum.
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))

endmodule

bind json_escape_crc32_stream jecs_checker u_jecs_checker (.*);

>>> tb/json_escape_crc32_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSON escape CRC-32 stream checker
// Watches the request and response channels of the block, predicts the
// running checksum for every accepted request and compares each accepted
// response with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module json_escape_crc32_checker
   import jecs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [0] escape_mode, [1] restart
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // [31:0] checksum
   output int          mismatches,
   output int          outstanding
);

   localparam int PRINT_CAP = 40;

   // Predicted checksums, oldest first.
   logic [31:0] checksum_queue[$];
   // Running CRC register as the block should hold it.
   logic [31:0] crc_shadow;
   int          fail_count;
   int          rsp_index;

   // Folds one byte into the reflected CRC, lowest data bit first.
   function automatic logic [31:0] crc_absorb(input logic [31:0] crc_in,
                                              input logic [7:0]  value);
      logic [31:0] crc;
      logic        feedback;
      crc = crc_in;
      for (int i = 0; i < 8; i++) begin
         feedback = crc[0] ^ value[i];
         crc = crc >> 1;
         if (feedback) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   // Expands one byte as a JSON string character; byte k sits at [8k +: 8].
   function automatic logic [47:0] json_expand(input  logic [7:0]  value,
                                               output int unsigned length);
      logic [7:0] tag;
      tag = 8'h00;
      case (value)
         CHR_QUOTE:     tag = CHR_QUOTE;
         CHR_BACKSLASH: tag = CHR_BACKSLASH;
         CHR_BS:        tag = CHR_LOW_B;
         CHR_FF:        tag = CHR_LOW_F;
         CHR_LF:        tag = CHR_LOW_N;
         CHR_CR:        tag = CHR_LOW_R;
         CHR_TAB:       tag = CHR_LOW_T;
         default:       tag = 8'h00;
      endcase
      if (tag != 8'h00) begin
         length = 2;
         return {32'h0000_0000, tag, CHR_BACKSLASH};
      end
      if (value == CHR_NUL) begin
         length = 6;
         return {CHR_ZERO, CHR_ZERO, CHR_ZERO, CHR_ZERO, CHR_LOW_U, CHR_BACKSLASH};
      end
      length = 1;
      return {40'h00_0000_0000, value};
   endfunction

   // Next CRC register value after one request.
   function automatic logic [31:0] crc_after_item(input logic [31:0] crc_now,
                                                  input logic [7:0]  value,
                                                  input logic        escape,
                                                  input logic        restart);
      logic [31:0] crc;
      logic [47:0] seq;
      int unsigned length;
      crc = restart ? CRC_ONES : crc_now;
      if (escape) begin
         seq = json_expand(value, length);
      end else begin
         seq = {40'h00_0000_0000, value};
         length = 1;
      end
      for (int k = 0; k < int'(length); k++) begin
         crc = crc_absorb(crc, seq[8*k +: 8]);
      end
      return crc;
   endfunction

   // Prints one mismatch line (up to a cap) and counts it.
   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_CAP) begin
         $display("checker: mismatch: %s", msg);
      end
   endtask

   initial begin
      crc_shadow  = CRC_ONES;
      fail_count  = 0;
      rsp_index   = 0;
   end

   // Compare first, then predict, so a new request never answers an older response.
   always @(posedge clock) begin
      logic [31:0] expected;
      if (reset) begin
         crc_shadow = CRC_ONES;
         checksum_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (checksum_queue.size() == 0) begin
               report_mismatch($sformatf("response %0d with no request waiting: %08h",
                                         rsp_index, rsp_tdata));
            end else begin
               expected = checksum_queue.pop_front();
               if (rsp_tdata !== expected) begin
                  report_mismatch($sformatf("response %0d checksum %08h, expected %08h",
                                            rsp_index, rsp_tdata, expected));
               end
            end
            rsp_index++;
         end
         if (req_tvalid && req_tready) begin
            crc_shadow = crc_after_item(crc_shadow, req_tdata, req_tuser[0], req_tuser[1]);
            checksum_queue.push_back(crc_shadow ^ CRC_ONES);
         end
      end
      mismatches  <= fail_count;
      outstanding <= checksum_queue.size();
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// JSON escape CRC-32 stream testbench
// Drives directed bytes covering every escape, then random JSON-like frames
// with random idling on both channels; the checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_top
   import jecs_pkg::*;
();

   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE       = 16;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic [1:0]  req_tuser;   // [0] escape_mode, [1] restart
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] checksum

   int mismatches;
   int outstanding;
   int cycle_count;
   int sent_count;
   // When set, neither side idles.
   bit calm;

   json_escape_crc32_stream i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   json_escape_crc32_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   function automatic int draw_wait();
      return calm ? 0 : int'($urandom_range(0, 7));
   endfunction

   // Response side: after each transaction, hold tready low for a drawn count.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
            stall_left = 0;
         end else begin
            if (rsp_tvalid && rsp_tready) begin
               stall_left = draw_wait();
            end
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Sends one request transaction after a drawn gap; returns at the accepting edge.
   task automatic send_item(input logic [7:0] value, input logic escape,
                            input logic restart);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= {restart, escape};
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Lowers tvalid and waits until every predicted checksum has arrived.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Picks a byte, favoring the ones that JSON escaping rewrites.
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(0, 9) < 4) begin
         case ($urandom_range(0, 7))
            0: return CHR_QUOTE;
            1: return CHR_BACKSLASH;
            2: return CHR_BS;
            3: return CHR_FF;
            4: return CHR_LF;
            5: return CHR_CR;
            6: return CHR_TAB;
            default: return CHR_NUL;
         endcase
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // One frame: mostly a restart first, then strings (escaped) and structure (raw), with rare flips.
   task automatic send_frame();
      int  length;
      bit  in_string;
      logic rs;
      length = $urandom_range(1, 16);
      in_string = 1'b0;
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            in_string = ~in_string;
         end
         // Restart mostly opens a frame; now and then it lands mid-frame.
         rs = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
         send_item(pick_byte(), in_string ^ ($urandom_range(0, 9) == 0), rs);
      end
   endtask

   // Stimulus and verdict.
   initial begin
      sent_count = 0;
      calm = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tuser  <= 2'b00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: seed after reset, every escape, plain bytes and restarts.
      send_item(8'h00, 1'b0, 1'b0);
      send_item(CHR_QUOTE, 1'b1, 1'b0);
      send_item(CHR_BACKSLASH, 1'b1, 1'b0);
      send_item(CHR_BS, 1'b1, 1'b0);
      send_item(CHR_FF, 1'b1, 1'b0);
      send_item(CHR_LF, 1'b1, 1'b0);
      send_item(CHR_CR, 1'b1, 1'b0);
      send_item(CHR_TAB, 1'b1, 1'b0);
      send_item(CHR_NUL, 1'b1, 1'b0);
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'h1F, 1'b1, 1'b0);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(CHR_QUOTE, 1'b0, 1'b0);
      send_item(CHR_LF, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      // Restart combined with the longest expansion.
      send_item(CHR_NUL, 1'b1, 1'b1);
      send_item(CHR_NUL, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(CHR_BACKSLASH, 1'b1, 1'b1);
      send_item(8'h41, 1'b0, 1'b0);
      calm = 1'b1;
      send_item(CHR_NUL, 1'b1, 1'b0);
      send_item(CHR_TAB, 1'b1, 1'b1);
      send_item(8'h80, 1'b0, 1'b0);
      calm = 1'b0;

      // Random frames; the sender pauses once halfway until all results are in.
      sent_count = 0;
      while (sent_count < RANDOM_ITEMS / 2) begin
         calm = ($urandom_range(0, 3) == 0);
         send_frame();
      end
      calm = 1'b0;
      drain_results();
      while (sent_count < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 3) == 0);
         send_frame();
      end
      calm = 1'b0;

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
